// ----- rtl/brb_pkg.sv -----
// Shared constants, types and helpers for the byte ring buffer core.
// No dependencies; used by brb_ctrl, brb_datapath and the top level.
package brb_pkg;

	// Ring geometry
	localparam int DEPTH     = 4096;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int MAX_BURST = 64;

	// Fixed field widths
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 7;
	localparam int FILL_W = 12;

	// Width that holds both a fill level and a burst count for compares
	localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Controller -> datapath commands
	typedef struct packed {
		logic load;      // capture the incoming transaction
		logic do_write;  // append (or drop) the captured byte
		logic do_empty;  // emit a read result with no byte
		logic do_read;   // pop one byte
	} brb_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic op_read;   // incoming op is a read
		logic n_zero;    // incoming read would return no byte
		logic last_byte; // current pop is the final one of the burst
	} brb_stat_t;

	// Ring index advance with wrap
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] nxt;
		if (idx == IDX_W'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = idx + IDX_W'(1);
		end
		return nxt;
	endfunction

endpackage

// ----- rtl/brb_ctrl.sv -----
// Controller state machine for the byte ring buffer core.
// Depends on brb_pkg; drives brb_datapath through brb_cmd_t / brb_stat_t.
module brb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  brb_pkg::brb_stat_t stat,
	output brb_pkg::brb_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WRITE = 4'b0010,
		S_EMPTY = 4'b0100,
		S_READ  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.do_write = (state_q == S_WRITE);
		cmd.do_empty = (state_q == S_EMPTY);
		cmd.do_read  = (state_q == S_READ);
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!stat.op_read) begin
						state_nxt = S_WRITE;
					end else if (stat.n_zero) begin
						state_nxt = S_EMPTY;
					end else begin
						state_nxt = S_READ;
					end
				end
			end
			S_WRITE: state_nxt = S_IDLE;
			S_EMPTY: state_nxt = S_IDLE;
			S_READ: begin
				if (stat.last_byte) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/brb_datapath.sv -----
// Datapath for the byte ring buffer core: byte store, ring indices,
// fill level, burst counters and the result register stage. Depends on brb_pkg.
module brb_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  brb_pkg::brb_cmd_t             cmd,
	output brb_pkg::brb_stat_t            stat,
	input  logic                          op,
	input  logic [brb_pkg::BYTE_W-1:0]    data_byte,
	input  logic [brb_pkg::CNT_W-1:0]     read_count,
	output logic                          strobe,
	output logic [brb_pkg::BYTE_W-1:0]    out_byte,
	output logic                          byte_valid,
	output logic                          last,
	output logic                          status,
	output logic [brb_pkg::FILL_W-1:0]    fill_count,
	output logic [brb_pkg::CNT_W-1:0]     bytes_read
);

	logic [brb_pkg::BYTE_W-1:0] mem [brb_pkg::DEPTH];
	logic [brb_pkg::BYTE_W-1:0] rdata_q;

	logic [brb_pkg::IDX_W-1:0]  head_q;
	logic [brb_pkg::IDX_W-1:0]  tail_q;
	logic [brb_pkg::IDX_W-1:0]  fill_q;
	logic [brb_pkg::BYTE_W-1:0] data_q;
	logic [brb_pkg::CNT_W-1:0]  remain_q;
	logic [brb_pkg::CNT_W-1:0]  nread_q;

	logic                       strobe_s1;
	logic                       valid_s1;
	logic                       last_s1;
	logic                       status_s1;
	logic [brb_pkg::IDX_W-1:0]  fill_s1;
	logic [brb_pkg::CNT_W-1:0]  nread_s1;

	logic                       full;
	logic                       wr_en;
	logic [brb_pkg::CNT_W-1:0]  want_sat;
	logic [brb_pkg::CNT_W-1:0]  n_take;

	// Burst size: saturate the request, then clip to what is stored
	always_comb begin
		if (read_count > brb_pkg::CNT_W'(brb_pkg::MAX_BURST)) begin
			want_sat = brb_pkg::CNT_W'(brb_pkg::MAX_BURST);
		end else begin
			want_sat = read_count;
		end
		if (brb_pkg::CMP_W'(want_sat) < brb_pkg::CMP_W'(fill_q)) begin
			n_take = want_sat;
		end else begin
			n_take = brb_pkg::CNT_W'(fill_q);
		end
	end

	assign full  = (fill_q == brb_pkg::IDX_W'(brb_pkg::DEPTH - 1));
	assign wr_en = cmd.do_write && !full;

	// Status to the controller
	always_comb begin
		stat           = '0;
		stat.op_read   = (op == brb_pkg::OP_READ);
		stat.n_zero    = (n_take == '0);
		stat.last_byte = (remain_q == brb_pkg::CNT_W'(1));
	end

	// Byte store: one write port at tail, one registered read port at head
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= data_q;
		end
		if (cmd.do_read) begin
			rdata_q <= mem[head_q];
		end
	end

	// Captured transaction payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q <= data_byte;
		end
	end

	// Ring indices, fill level and burst counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			remain_q <= '0;
			nread_q  <= '0;
		end else begin
			if (cmd.load) begin
				remain_q <= n_take;
				nread_q  <= '0;
			end
			if (wr_en) begin
				tail_q <= brb_pkg::next_idx(tail_q);
				fill_q <= fill_q + brb_pkg::IDX_W'(1);
			end
			if (cmd.do_read) begin
				head_q   <= brb_pkg::next_idx(head_q);
				fill_q   <= fill_q - brb_pkg::IDX_W'(1);
				remain_q <= remain_q - brb_pkg::CNT_W'(1);
				nread_q  <= nread_q + brb_pkg::CNT_W'(1);
			end
		end
	end

	// Result stage, lines up with the registered store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			strobe_s1 <= cmd.do_write || cmd.do_empty || cmd.do_read;
			valid_s1  <= cmd.do_read;
			last_s1   <= cmd.do_read ? (remain_q == brb_pkg::CNT_W'(1)) : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= cmd.do_write && full;
		nread_s1  <= cmd.do_read ? (nread_q + brb_pkg::CNT_W'(1)) : '0;
		if (wr_en) begin
			fill_s1 <= fill_q + brb_pkg::IDX_W'(1);
		end else if (cmd.do_read) begin
			fill_s1 <= fill_q - brb_pkg::IDX_W'(1);
		end else begin
			fill_s1 <= fill_q;
		end
	end

	// Result ports
	assign strobe     = strobe_s1;
	assign byte_valid = valid_s1;
	assign out_byte   = valid_s1 ? rdata_q : '0;
	assign last       = last_s1;
	assign status     = status_s1;
	assign fill_count = brb_pkg::FILL_W'(fill_s1);
	assign bytes_read = nread_s1;

endmodule

// ----- rtl/byte_ring_buffer_bulk_read_core.sv -----
// Top level of the byte ring buffer core with burst reads.
// Depends on brb_pkg, brb_ctrl and brb_datapath.
//
//  channel   handshake             fields
//  input     start & !busy         op, data_byte, read_count
//  result    strobe (one cycle)    out_byte, byte_valid, last, status,
//                                  fill_count, bytes_read
//
// A write or an empty read passes through its controller state, a read of n bytes
// through the read state, one byte per cycle through the single store read port, and
// each result is registered in the result stage. busy is high while the controller
// is in a write, empty or read state; the final result shows in the cycle busy falls,
// so the next start can overlap it. Reset clears the indices and the fill level; the
// store is not cleared. The receiver cannot stall: every result is shown for one cycle only.
module byte_ring_buffer_bulk_read_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [brb_pkg::BYTE_W-1:0] data_byte,
	input  logic [brb_pkg::CNT_W-1:0]  read_count,
	output logic                       strobe,
	output logic [brb_pkg::BYTE_W-1:0] out_byte,
	output logic                       byte_valid,
	output logic                       last,
	output logic                       status,
	output logic [brb_pkg::FILL_W-1:0] fill_count,
	output logic [brb_pkg::CNT_W-1:0]  bytes_read
);

	brb_pkg::brb_cmd_t  cmd;
	brb_pkg::brb_stat_t stat;

	// Sequencer
	brb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Store, indices and result stage
	brb_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (op),
		.data_byte  (data_byte),
		.read_count (read_count),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.status     (status),
		.fill_count (fill_count),
		.bytes_read (bytes_read)
	);

endmodule
